### rtl/ttg_pkg.sv
`default_nettype none

package ttg_pkg;

  // field widths
  localparam int FREQ_W     = 15;
  localparam int HZ_W       = 16;
  localparam int DUR_W      = 8;
  localparam int CNT_W      = 20;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // reset value of the max frequency register
  localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd15625;

  // hz / 10 by reciprocal multiply, exact for 16-bit operands
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;
  localparam int          HZ10_W      = 12;
  localparam int          PROD10_W    = 31;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = FREQ_W;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_PLAY = 2'd1,
    REQ_OFF  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic prep;
    logic div_step;
    logic apply;
    logic out_load;
  } ttg_cmd_t;

  typedef struct packed {
    logic in_play;
    logic div_last;
    logic out_free;
    logic active;
    logic cnt_zero;
  } ttg_sts_t;

endpackage

`default_nettype wire

### rtl/ttg_ctrl.sv
`default_nettype none

module ttg_ctrl
  import ttg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ttg_sts_t sts_i,
  output ttg_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_APPLY  = 6'b010000,
    ST_RESULT = 6'b100000
  } ttg_state_e;

  ttg_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load     = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.in_play ? ST_PREP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESULT;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ttg_datapath.sv
`default_nettype none

module ttg_datapath
  import ttg_pkg::*;
#(
  parameter int TIMER_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ttg_cmd_t              cmd_i,
  output ttg_sts_t                   sts_o,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic [REQ_W-1:0]      in_req_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [FREQ_W-1:0]     cfg_wdata_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  // captured request
  req_e              req_q;
  logic [HZ_W-1:0]   hz_in_q;
  logic [DUR_W-1:0]  dur_q;
  logic [FREQ_W-1:0] maxf_q;

  // divider and period math
  logic [FREQ_W-1:0]    hz_q;
  logic [HZ10_W-1:0]    hz10_q;
  logic [FREQ_W-1:0]    rem_q;
  logic [FREQ_W-1:0]    dvd_q;
  logic [FREQ_W-1:0]    quot_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic                 divz_q;

  // tone state
  logic [TIMER_BITS-1:0] reload_q, reload_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic                  pin_q, pin_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  act_q, act_d;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [FREQ_W-1:0]     lo_freq;
  logic [HZ_W-1:0]       hz_lo;
  logic [FREQ_W-1:0]     hz_cl;
  logic [FREQ_W:0]       rem_sh;
  logic                  rem_ge;
  logic [FREQ_W:0]       rem_sub;
  logic [PROD10_W-1:0]   prod10;
  logic [31:0]           neg_ratio;
  logic [TIMER_BITS-1:0] reload_nx;
  logic [CNT_W-1:0]      cnt_nx;
  logic [CNT_W-1:0]      cnt_dec;

  // frequency clamp to [max >> TIMER_BITS, max]
  assign lo_freq = maxf_q >> TIMER_BITS;
  assign hz_lo   = (hz_in_q < {1'b0, lo_freq}) ? {1'b0, lo_freq} : hz_in_q;
  assign hz_cl   = (hz_lo > {1'b0, maxf_q}) ? maxf_q : hz_lo[FREQ_W-1:0];

  // one restoring step of max / hz
  assign rem_sh  = {rem_q, dvd_q[FREQ_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, hz_q});
  assign rem_sub = rem_sh - {1'b0, hz_q};

  assign prod10 = PROD10_W'(hz_q) * PROD10_W'(DIV10_MUL);

  // reload is the two's complement of the ratio, cut to the timer width
  assign neg_ratio = 32'd0 - (divz_q ? 32'd0 : 32'(quot_q));
  assign reload_nx = neg_ratio[TIMER_BITS-1:0];
  assign cnt_nx    = CNT_W'(hz10_q) * CNT_W'(dur_q);
  assign cnt_dec   = (cnt_q != '0) ? (cnt_q - CNT_W'(1)) : cnt_q;

  always_comb begin
    reload_d = reload_q;
    timer_d  = timer_q;
    pin_d    = pin_q;
    cnt_d    = cnt_q;
    act_d    = act_q;
    if (cmd_i.exec) begin
      case (req_q)
        REQ_TICK: begin
          if (act_q) begin
            if (timer_q != '1) begin
              timer_d = timer_q + TIMER_BITS'(1);
            end else begin
              timer_d = reload_q;
              pin_d   = ~pin_q;
              // falling edge closes one period
              if (pin_q) begin
                cnt_d = cnt_dec;
                if (cnt_dec == '0) begin
                  act_d = 1'b0;
                end
              end
            end
          end
        end
        REQ_OFF: begin
          act_d = 1'b0;
          pin_d = 1'b0;
        end
        REQ_PLAY, REQ_NONE: begin
          act_d = act_q;
        end
        default: begin
          act_d = act_q;
        end
      endcase
    end else if (cmd_i.apply) begin
      reload_d = reload_nx;
      timer_d  = reload_nx;
      cnt_d    = cnt_nx;
      if (cnt_nx == '0) begin
        act_d = 1'b0;
        pin_d = 1'b0;
      end else begin
        act_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxf_q      <= FREQ_RESET;
      reload_q    <= '0;
      timer_q     <= '0;
      pin_q       <= 1'b0;
      cnt_q       <= '0;
      act_q       <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        maxf_q <= cfg_wdata_i;
      end
      reload_q <= reload_d;
      timer_q  <= timer_d;
      pin_q    <= pin_d;
      cnt_q    <= cnt_d;
      act_q    <= act_d;
      if (cmd_i.prep) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_e'(in_req_i);
      hz_in_q <= in_data_i[HZ_W-1:0];
      dur_q   <= in_data_i[HZ_W +: DUR_W];
    end
    if (cmd_i.prep) begin
      hz_q   <= hz_cl;
      divz_q <= (hz_cl == '0);
      rem_q  <= '0;
      dvd_q  <= maxf_q;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
      dvd_q  <= {dvd_q[FREQ_W-2:0], 1'b0};
      quot_q <= {quot_q[FREQ_W-2:0], rem_ge};
      hz10_q <= prod10[DIV10_SHIFT +: HZ10_W];
    end
    if (cmd_i.out_load) begin
      out_data_q <= {(OUT_DATA_W - CNT_W - 2)'(0), cnt_q, act_q, pin_q};
    end
  end

  assign sts_o.in_play  = (in_req_i == REQ_PLAY);
  assign sts_o.div_last = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.active   = act_q;
  assign sts_o.cnt_zero = (cnt_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/timed_tone_generator_core.sv
// sequence: a tick, off or ignored request goes through execute, then result load; a play
//   request goes through clamp, 15 divider steps of max_frequency / hz, apply, result load
// one request at a time: a new request is taken only after the last result is loaded, and
//   the result load waits while the output register still holds an untaken result
// reset: rst_ni is asynchronous, active low; tone idle, pin low, count zero,
//   max_frequency back to 15625
`default_nettype none

module timed_tone_generator_core
  import ttg_pkg::*;
#(
  parameter int TIMER_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config: max_frequency
  input  wire logic                  cfg_we_i,
  input  wire logic [FREQ_W-1:0]     cfg_wdata_i,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // tone_hz[15:0], duration_tenths[23:16]
  input  wire logic [REQ_W-1:0]      s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // tone_out[0], playing[1],
                                                     // periods_left[21:2], zero[23:22]
);

  ttg_cmd_t cmd;
  ttg_sts_t sts;

  // controller: sequences one request at a time, accepts only when idle
  ttg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: clamp, serial divider, period multiply, tone timer, output register
  ttg_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_req_i    (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // a running tone always has periods left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.active |-> !sts.cnt_zero)
    else $error("tone active with zero period count");

  // a result only appears after the controller loads it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // one request at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

endmodule

`default_nettype wire
